/* hdl/positional_list_store_defines.svh */
// ----------------------------------------------------------------------------
// positional list store assertion macros
// concurrent checks clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("positional list store check failed");
`define PLS_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("positional list store forbidden condition");
`else
`define PLS_ASSERT(label, prop)
`define PLS_NEVER(label, cond)
`endif

`endif

/* hdl/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// shared codes, widths and state type of the positional list store
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int FUNC_W = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 6;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_COUNT     = 3'd6;
  localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DN,
    S_DUMP
  } state_t;

endpackage

`default_nettype wire

/* hdl/pls_if.sv */
// ----------------------------------------------------------------------------
// pls channel interfaces
// valid/ready channels for operation requests and list results
// ----------------------------------------------------------------------------
`default_nettype none

interface pls_in_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface pls_out_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] element;
  logic [LEN_W-1:0]         length;
  logic                     last;

  modport source (output valid, status, element, length, last, input ready);
  modport sink   (input valid, status, element, length, last, output ready);
endinterface

`default_nettype wire

/* hdl/pls_ram.sv */
// ----------------------------------------------------------------------------
// pls_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/positional_list_store.sv */
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of signed words kept packed in one ram, front at address 0
// ----------------------------------------------------------------------------
// One operation is taken at a time; the request side is ready again once the
// previous operation has finished and the result register can take a new
// result. Count, rejected operations, insert at the back, insert at position
// count+1 and delete of the last element finish without leaving idle.
// Insert at front or at position p moves (count - p + 1) entries and then
// writes the new value. Delete at front or at position p moves (count - p)
// entries. A dump gives one result per cycle when the result side never
// stalls. The moves go through the single ram, which moves one entry per
// cycle through its read and write port. The list memory needs no clearing
// after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_store_defines.svh"

module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  pls_in_if.sink     req,
  pls_out_if.source  rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = POS_W + 1;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] rptr, rptr_next;
  logic signed [DATA_W-1:0] val, val_next;

  logic ovalid;
  logic [STAT_W-1:0] ostatus;
  logic signed [DATA_W-1:0] oelement;
  logic [LEN_W-1:0] olength;
  logic olast;

  logic ld;
  logic [STAT_W-1:0] ld_status;
  logic signed [DATA_W-1:0] ld_element;
  logic ld_last;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  logic accept, out_free;
  logic [XW-1:0] cnt_x, pos_x;
  logic full, empty, ins_bad, del_bad;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_addr, pos_addr;

  pls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign cnt_x     = XW'(cnt);
  assign pos_x     = XW'(req.position);
  assign full      = (cnt_x == XW'(CAPACITY));
  assign empty     = (cnt == '0);
  assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign del_bad   = (pos_x == '0) || (pos_x > cnt_x);
  assign cnt_m1    = cnt - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign pos_addr  = AW'(req.position - POS_W'(1));

  always_comb begin
    logic [AW-1:0]     at;
    logic [STAT_W-1:0] st;

    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    rptr_next  = rptr;
    val_next   = val;
    ld         = 1'b0;
    ld_status  = ST_OK;
    ld_element = '0;
    ld_last    = 1'b1;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    at         = '0;
    st         = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
              if (req.func == FN_INS_FRONT) begin
                at = '0;
              end else if (req.func == FN_INS_BACK) begin
                at = AW'(cnt);
              end else begin
                at = pos_addr;
              end
              if (req.func == FN_INS_POS && ins_bad) begin
                st = ST_BADPOS;
              end else if (full) begin
                st = ST_FULL;
              end
              if (st != ST_OK) begin
                ld        = 1'b1;
                ld_status = st;
              end else if (CW'(at) == cnt) begin
                // append: nothing to move
                we       = 1'b1;
                waddr    = at;
                wdata    = req.value;
                cnt_next = cnt + CW'(1);
                ld       = 1'b1;
              end else begin
                idx_next   = at;
                val_next   = req.value;
                rptr_next  = last_addr;
                raddr      = last_addr;
                state_next = S_SHIFT_UP;
              end
            end
            FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
              if (req.func == FN_DEL_FRONT) begin
                at = '0;
              end else if (req.func == FN_DEL_BACK) begin
                at = last_addr;
              end else begin
                at = pos_addr;
              end
              if (empty) begin
                st = ST_EMPTY;
              end else if (req.func == FN_DEL_POS && del_bad) begin
                st = ST_BADPOS;
              end
              if (st != ST_OK) begin
                ld        = 1'b1;
                ld_status = st;
              end else if (at == last_addr) begin
                cnt_next = cnt_m1;
                ld       = 1'b1;
              end else begin
                rptr_next  = at + AW'(1);
                raddr      = at + AW'(1);
                state_next = S_SHIFT_DN;
              end
            end
            FN_COUNT: begin
              ld = 1'b1;
            end
            FN_DUMP: begin
              if (empty) begin
                ld = 1'b1;
              end else begin
                rptr_next  = '0;
                raddr      = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end

      // move entries up one place, highest first; rdata holds entry rptr
      S_SHIFT_UP: begin
        we    = 1'b1;
        waddr = rptr + AW'(1);
        wdata = rdata;
        if (rptr == idx) begin
          state_next = S_INS_WR;
        end else begin
          rptr_next = rptr - AW'(1);
          raddr     = rptr - AW'(1);
        end
      end

      S_INS_WR: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = val;
        cnt_next   = cnt + CW'(1);
        ld         = 1'b1;
        state_next = S_IDLE;
      end

      // move entries down one place, lowest first
      S_SHIFT_DN: begin
        we    = 1'b1;
        waddr = rptr - AW'(1);
        wdata = rdata;
        if (rptr == last_addr) begin
          cnt_next   = cnt_m1;
          ld         = 1'b1;
          state_next = S_IDLE;
        end else begin
          rptr_next = rptr + AW'(1);
          raddr     = rptr + AW'(1);
        end
      end

      // keep rereading the same entry while the result side stalls
      S_DUMP: begin
        raddr = rptr;
        if (out_free) begin
          ld         = 1'b1;
          ld_element = rdata;
          ld_last    = (rptr == last_addr);
          if (rptr == last_addr) begin
            state_next = S_IDLE;
          end else begin
            rptr_next = rptr + AW'(1);
            raddr     = rptr + AW'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (ld) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    rptr <= rptr_next;
    val  <= val_next;
    if (ld) begin
      ostatus  <= ld_status;
      oelement <= ld_element;
      olength  <= LEN_W'(cnt_next);
      olast    <= ld_last;
    end
  end

  assign rsp.valid   = ovalid;
  assign rsp.status  = ostatus;
  assign rsp.element = oelement;
  assign rsp.length  = olength;
  assign rsp.last    = olast;

  `PLS_NEVER(a_cnt_bound, CW'(cnt) > CW'(CAPACITY))
  `PLS_NEVER(a_result_overrun, ld && ovalid && !rsp.ready)
  `PLS_ASSERT(a_cnt_step, (!$past(rst) && cnt != $past(cnt)) |-> (cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
  `PLS_ASSERT(a_dump_in_range, (state == S_DUMP) |-> (CW'(rptr) < cnt))
  `PLS_ASSERT(a_shift_clear_out, (state == S_SHIFT_UP || state == S_INS_WR || state == S_SHIFT_DN) |-> !ovalid)

endmodule

`default_nettype wire
